FILE: hw/rtl/crc8d_pkg.sv
package crc8d_pkg;

    localparam logic [7:0] CRC_POLY = 8'hD8;
    localparam logic [7:0] PREAMBLE = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
    } t_result;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] rem, input logic [7:0] b);
        logic [7:0] r;
        r = rem ^ b;
        for (int k = 0; k < 8; k++) begin
            if (r[7]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/crc8_serial_frame_deframer.sv
// Serial frame deframer with CRC-8 check.
// Input channel (i_valid / o_ready / i_rx_byte) takes one received byte per item.
// The block hunts for two 0xFF preamble bytes, reads a length byte, then, unless
// the length is zero, a type byte and payload bytes, and one CRC byte closing the frame.
// Output channel (o_valid / i_ready) gives one item per payload byte (kind 0)
// and one end item per frame (kind 1 crc good, kind 2 crc bad, o_frame_end 1).
// Preamble, length and type bytes give no output item.
// A byte sits in the input register from its accepting edge; its result is loaded
// into the output register when that byte leaves the input register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// combinational crc byte step and parser update between the input and output registers.
// When the receiver stalls, the output register holds its item; the input
// register still takes a byte and passes bytes that give no result, and
// o_ready drops only while a result-bearing byte waits for the output register.
// Synchronous active-low reset empties both registers and returns the parser
// to the hunt for the first preamble byte.
module crc8_serial_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic       o_frame_end
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    crc8d_pkg::t_result r_out;
    logic               in_adv;
    logic               in_accept;
    logic               core_has;
    crc8d_pkg::t_result core_result;

    crc8d_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_adv),
        .i_byte       (r_in_byte),
        .o_has_result (core_has),
        .o_result     (core_result)
    );

    assign in_adv    = r_in_valid && (!core_has || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || in_adv;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (in_adv) begin
                r_in_valid <= 1'b0;
            end
            if (in_adv && core_has) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (in_adv && core_has) begin
            r_out <= core_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_frame_type = r_out.frame_type;
    assign o_data_byte  = r_out.data_byte;
    assign o_byte_index = r_out.byte_index;
    assign o_frame_end  = r_out.frame_end;

endmodule

FILE: hw/rtl/crc8d_core.sv
module crc8d_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output logic                 o_has_result,
    output crc8d_pkg::t_result   o_result
);

    crc8d_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_type, n_type;
    logic [7:0] r_pos, n_pos;
    logic [7:0] left_dec;
    logic [7:0] crc_step;

    assign left_dec = r_bytes_left - 8'd1;
    assign crc_step = crc8d_pkg::crc8_byte(r_crc, i_byte);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_type       = r_type;
        n_pos        = r_pos;
        unique case (r_phase)
            crc8d_pkg::PH_HUNT2: begin
                n_phase = (i_byte == crc8d_pkg::PREAMBLE) ? crc8d_pkg::PH_LENGTH
                                                          : crc8d_pkg::PH_HUNT1;
            end
            crc8d_pkg::PH_LENGTH: begin
                n_bytes_left = i_byte;
                n_crc        = 8'd0;
                n_type       = 8'd0;
                n_pos        = 8'd0;
                n_phase      = (i_byte == 8'd0) ? crc8d_pkg::PH_CRC : crc8d_pkg::PH_TYPE;
            end
            crc8d_pkg::PH_TYPE: begin
                n_type       = i_byte;
                n_crc        = crc_step;
                n_bytes_left = left_dec;
                n_phase      = (left_dec == 8'd0) ? crc8d_pkg::PH_CRC
                                                  : crc8d_pkg::PH_PAYLOAD;
            end
            crc8d_pkg::PH_PAYLOAD: begin
                n_crc        = crc_step;
                n_pos        = r_pos + 8'd1;
                n_bytes_left = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = crc8d_pkg::PH_CRC;
                end
            end
            crc8d_pkg::PH_CRC: begin
                n_phase = crc8d_pkg::PH_HUNT1;
            end
            default: begin
                // first preamble hunt, unused codes too
                n_phase = (i_byte == crc8d_pkg::PREAMBLE) ? crc8d_pkg::PH_HUNT2
                                                          : crc8d_pkg::PH_HUNT1;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_has_result        = 1'b0;
        o_result.kind       = crc8d_pkg::KIND_PAYLOAD;
        o_result.frame_type = r_type;
        o_result.data_byte  = i_byte;
        o_result.byte_index = 8'd0;
        o_result.frame_end  = 1'b0;
        unique case (r_phase)
            crc8d_pkg::PH_PAYLOAD: begin
                o_has_result        = 1'b1;
                o_result.byte_index = r_pos;
            end
            crc8d_pkg::PH_CRC: begin
                o_has_result       = 1'b1;
                o_result.kind      = (i_byte == r_crc) ? crc8d_pkg::KIND_GOOD
                                                       : crc8d_pkg::KIND_BAD;
                o_result.frame_end = 1'b1;
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= crc8d_pkg::PH_HUNT1;
            r_bytes_left <= 8'd0;
            r_crc        <= 8'd0;
            r_type       <= 8'd0;
            r_pos        <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_type       <= n_type;
            r_pos        <= n_pos;
        end
    end

endmodule

FILE: hw/rtl/crc8d_checker.sv
module crc8d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_frame_type,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_byte_index,
    input logic       o_frame_end
);

    // no item survives reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output item valid after reset");

    // end items carry a crc verdict and index zero, payload items never end a frame
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |->
            ((o_kind == crc8d_pkg::KIND_GOOD || o_kind == crc8d_pkg::KIND_BAD)
             && o_byte_index == 8'd0))
        else $error("bad end item");

    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_end) |-> (o_kind == crc8d_pkg::KIND_PAYLOAD))
        else $error("non-end item with end kind");

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_kind) && $stable(o_data_byte)
             && $stable(o_byte_index) && $stable(o_frame_type) && $stable(o_frame_end)))
        else $error("stalled output item changed");

    // a waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_rx_byte)))
        else $error("waiting input item changed");

endmodule

bind crc8_serial_frame_deframer crc8d_checker u_crc8d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_rx_byte    (i_rx_byte),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_frame_type (o_frame_type),
    .o_data_byte  (o_data_byte),
    .o_byte_index (o_byte_index),
    .o_frame_end  (o_frame_end)
);
